// ----- hdl/swa_pkg.sv -----
// Shared sizes, types and helpers for the sliding window average unit.
// No dependencies; the divider, the top and the checker in hdl/ use this package.
`default_nettype none

package swa_pkg;

    // Storage sizing
    localparam int MAX_WINDOW   = 256;
    localparam int SAMPLE_BITS  = 16;
    localparam int WINDOW_RESET = 16;

    // Fixed field widths of the ports
    localparam int CFG_W     = 9;
    localparam int OUT_W     = 24;
    localparam int CNT_OUT_W = 9;
    localparam int FRAC_BITS = 8;

    // Derived widths
    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int QUO_W  = NUM_W + 1;
    localparam int SAT_W  = (QUO_W > OUT_W) ? QUO_W : OUT_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Output clamp limits
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

    // Divider request and response
    typedef struct packed {
        logic                     start;
        logic signed [NUM_W-1:0]  numer;
        logic        [CNT_W-1:0]  denom;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [QUO_W-1:0]  quotient;
    } div_rsp_t;

    // Clamp a wide signed value to the signed output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] r;
        begin
            if (v > SAT_HI)
            begin
                r = SAT_HI;
            end
            else if (v < SAT_LO)
            begin
                r = SAT_LO;
            end
            else
            begin
                r = v;
            end
            return r[OUT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/swa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/swa_divider.sv -----
// Bit-serial signed divider: numerator by an unsigned nonzero count,
// quotient truncated toward zero. Depends on swa_pkg.
`default_nettype none

module swa_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire swa_pkg::div_req_t req,
    output swa_pkg::div_rsp_t      rsp
);

    import swa_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;

    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic              fits;
    logic [NUM_W-1:0]  mag;
    logic [QUO_W-1:0]  quo_ext;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
        mag       = req.numer[NUM_W-1] ? NUM_W'(-req.numer) : NUM_W'(req.numer);
    end

    // Sequence the steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(NUM_W);
            rem_next  = '0;
            quo_next  = mag;
            dvs_next  = req.denom;
            neg_next  = req.numer[NUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Restore the sign of the quotient
    always_comb
    begin
        quo_ext      = {1'b0, quo_reg};
        rsp.done     = done_reg;
        rsp.quotient = neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
    end

endmodule

`default_nettype wire

// ----- hdl/sliding_window_average_unit.sv -----
// Boxcar moving average: the most recent win_length samples are kept in a
// ring RAM with a running sum and fill count; each input item yields one
// result with the window sum, the count and the mean in signed Q8 rounded
// toward zero, window_sum and mean_q8 clamped to 24 bits. One item is in
// work at a time and passes through the ring read, the sum update, the
// divider start, the NUM_W = 33 steps of the bit-serial divider and the
// result load. A finished result waits in the output register while the
// next item is taken. Writing win_length (0 reads as 1, values above
// 256 as 256) empties the window; the ring itself is never cleared, since
// an old entry is only used after it has been written. Depends on swa_pkg,
// swa_ram and swa_divider.
`default_nettype none

module sliding_window_average_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [swa_pkg::CFG_W-1:0]             win_length,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [swa_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [swa_pkg::OUT_W-1:0]           window_sum,
    output logic [swa_pkg::CNT_OUT_W-1:0]              sample_count,
    output logic signed [swa_pkg::OUT_W-1:0]           mean_q8
);

    import swa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              win_reg, win_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [ADDR_W-1:0]             pos_reg, pos_next;
    logic signed [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [ADDR_W-1:0]             slot_reg, slot_next;
    logic                          full_reg, full_next;

    logic                          ovld_reg, ovld_next;
    logic signed [OUT_W-1:0]       osum_reg, osum_next;
    logic [CNT_OUT_W-1:0]          ocnt_reg, ocnt_next;
    logic signed [OUT_W-1:0]       omean_reg, omean_next;

    logic                          in_take;
    logic                          cfg_take;
    logic                          out_free;
    logic [CMP_W-1:0]              cfg_ext;
    logic [CMP_W-1:0]              cfg_clamp;
    logic [ADDR_W-1:0]             slot_sel;
    logic [CNT_W-1:0]              slot_inc;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] old_smp;
    logic signed [SUM_W-1:0]       old_term;

    div_req_t                      div_req;
    div_rsp_t                      div_rsp;

    // Handshakes: config has priority over a new item in idle
    always_comb
    begin
        cfg_ready = (state_reg == S_IDLE);
        in_stall  = (state_reg != S_IDLE) || cfg_valid;
        cfg_take  = cfg_valid && cfg_ready;
        in_take   = in_valid && !in_stall;
        out_free  = !ovld_reg || !out_stall;
    end

    // Clamp the written window length
    always_comb
    begin
        cfg_ext = CMP_W'(win_length);
        if (cfg_ext == '0)
        begin
            cfg_clamp = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_WINDOW))
        begin
            cfg_clamp = CMP_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_clamp = cfg_ext;
        end
    end

    // Ring slot for the new sample and the next write position
    always_comb
    begin
        slot_sel = (CNT_W'(pos_reg) >= win_reg) ? '0 : pos_reg;
        slot_inc = CNT_W'(slot_reg) + CNT_W'(1);
        old_smp  = $signed(ram_rdata);
        old_term = full_reg ? SUM_W'(old_smp) : '0;
    end

    // Sample ring
    swa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == S_READ),
        .waddr (slot_reg),
        .wdata (smp_reg),
        .re    (in_take),
        .raddr (slot_sel),
        .rdata (ram_rdata)
    );

    // Mean divider
    always_comb
    begin
        div_req.start = (state_reg == S_START);
        div_req.numer = {sum_reg, {FRAC_BITS{1'b0}}};
        div_req.denom = cnt_reg;
    end

    swa_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer and window state
    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        smp_next   = smp_reg;
        slot_next  = slot_reg;
        full_next  = full_reg;
        ovld_next  = ovld_reg && out_stall;
        osum_next  = osum_reg;
        ocnt_next  = ocnt_reg;
        omean_next = omean_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_take)
                begin
                    win_next = cfg_clamp[CNT_W-1:0];
                    sum_next = '0;
                    cnt_next = '0;
                    pos_next = '0;
                end
                else if (in_take)
                begin
                    smp_next   = sample;
                    slot_next  = slot_sel;
                    full_next  = (cnt_reg >= win_reg);
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // Drop the oldest sample once full, add the new one
                sum_next   = sum_reg - old_term + SUM_W'(smp_reg);
                cnt_next   = full_reg ? cnt_reg : cnt_reg + CNT_W'(1);
                pos_next   = (slot_inc >= win_reg) ? '0 : slot_inc[ADDR_W-1:0];
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Load the result once the output register is free
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    osum_next  = sat_out(SAT_W'(sum_reg));
                    ocnt_next  = CNT_OUT_W'(cnt_reg);
                    omean_next = sat_out(SAT_W'(div_rsp.quotient));
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            win_reg   <= CNT_W'(WINDOW_RESET);
            sum_reg   <= '0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        slot_reg  <= slot_next;
        full_reg  <= full_next;
        osum_reg  <= osum_next;
        ocnt_reg  <= ocnt_next;
        omean_reg <= omean_next;
    end

    // Result port
    always_comb
    begin
        out_valid    = ovld_reg;
        window_sum   = osum_reg;
        sample_count = ocnt_reg;
        mean_q8      = omean_reg;
    end

endmodule

`default_nettype wire

// ----- hdl/swa_checker.sv -----
// Port-level checks for the sliding window average unit, bound to the top.
// Depends on swa_pkg and sliding_window_average_unit.
`default_nettype none

module swa_checker (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   cfg_valid,
    input wire logic                                   cfg_ready,
    input wire logic                                   in_valid,
    input wire logic                                   in_stall,
    input wire logic                                   out_valid,
    input wire logic                                   out_stall,
    input wire logic signed [swa_pkg::OUT_W-1:0]       window_sum,
    input wire logic [swa_pkg::CNT_OUT_W-1:0]          sample_count,
    input wire logic signed [swa_pkg::OUT_W-1:0]       mean_q8
);

    // A held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Every result covers at least one sample
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_count != '0)
        else $error("result with empty window");

    // Mean carries the sign of the sum
    a_mean_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mean_q8 == '0) || (mean_q8[swa_pkg::OUT_W-1] ==
            window_sum[swa_pkg::OUT_W-1]))
        else $error("mean sign differs from sum sign");

    // An accepted item keeps the input side busy for the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !cfg_ready)
        else $error("input taken again while item in work");

    // A config write never coincides with an accepted item
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> in_stall)
        else $error("config write and item accepted together");

endmodule

bind sliding_window_average_unit swa_checker u_swa_checker (.*);

`default_nettype wire
